@@ rtl/led_bar_serial_display_driver_defines.svh @@
// ---------------------------------------------------------------------------
// LED bar serial display driver: assertion macros
// Shared helpers for the concurrent checks in the driver's RTL.
// ---------------------------------------------------------------------------
`ifndef LED_BAR_SERIAL_DISPLAY_DRIVER_DEFINES_SVH
`define LED_BAR_SERIAL_DISPLAY_DRIVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LBSD_ASSERT_NOW(label, ck, rstn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LBSD_ASSERT_NEXT(label, ck, rstn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lbsd_pkg.sv @@
// ---------------------------------------------------------------------------
// LED bar serial display driver: package
// Constants, types and a helper function shared by the driver's modules.
// ---------------------------------------------------------------------------
package lbsd_pkg;

    localparam int BAR_SEGMENTS = 20;
    localparam int CACHE_WORDS  = 16;
    localparam int BAR_POSITIONS = 20;

    localparam int CACHE_AW   = (CACHE_WORDS > 1) ? $clog2(CACHE_WORDS) : 1;
    localparam int CNT_W      = $clog2(BAR_SEGMENTS + 1);
    localparam int GRP_W      = 3;
    localparam int FLUSH_GRPS = (CACHE_WORDS + 1) / 2;
    localparam int BAR_GRPS   = 4;

    localparam logic [7:0] CMD_FIXED    = 8'h44;
    localparam logic [7:0] CMD_ADDR     = 8'hC0;
    localparam logic [7:0] CMD_DISP_ON  = 8'h88;
    localparam logic [7:0] CMD_DISP_OFF = 8'h80;
    localparam logic [7:0] MAX_BRIGHT   = 8'd7;

    localparam logic [2:0] OP_BAR     = 3'd0;
    localparam logic [2:0] OP_DISPLAY = 3'd1;
    localparam logic [2:0] OP_RAW     = 3'd2;
    localparam logic [2:0] OP_FLUSH   = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_FIXED,
        ST_ADDR,
        ST_DATA0,
        ST_DATA1
    } seq_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       strobe_release;
        logic       last_byte;
    } out_byte_t;

    typedef struct packed {
        logic                wr_en;
        logic [CACHE_AW-1:0] wr_addr;
        logic [7:0]          wr_data;
        logic                clear;
        logic [CACHE_AW-1:0] rd_addr;
    } cache_req_t;

    // Segment byte of a bar for a lit count: byte 0/1 low/high of the
    // first grid, byte 2/3 low/high of the second grid.
    function automatic logic [7:0] therm_byte(input logic [CNT_W-1:0] count,
                                              input logic [1:0] grp);
        logic [BAR_POSITIONS-1:0] mask;
        logic [7:0]               result;
        for (int i = 0; i < BAR_POSITIONS; i++) begin
            mask[i] = (i < int'(count));
        end
        case (grp)
            2'd0:    result = mask[7:0];
            2'd1:    result = {6'b0, mask[9:8]};
            2'd2:    result = mask[17:10];
            2'd3:    result = {6'b0, mask[19:18]};
            default: result = 8'h00;
        endcase
        return result;
    endfunction

endpackage

@@ rtl/lbsd_cache.sv @@
// ---------------------------------------------------------------------------
// LED bar serial display driver: segment cache
// Synchronous segment byte memory with one write port and one registered
// read port; per-entry valid bits make unwritten entries read as zero.
// ---------------------------------------------------------------------------
module lbsd_cache (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lbsd_pkg::cache_req_t req,
    output logic [7:0]           rd_data
);

    logic [7:0]                    mem [lbsd_pkg::CACHE_WORDS];
    logic [lbsd_pkg::CACHE_WORDS-1:0] valid_reg;
    logic [lbsd_pkg::CACHE_WORDS-1:0] valid_next;
    logic [7:0]                    rd_data_reg;
    logic                          rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (req.clear)
        begin
            valid_next = '0;
        end
        if (req.wr_en)
        begin
            valid_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[req.rd_addr] && !req.clear;
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : 8'h00;

endmodule

@@ rtl/lbsd_seq.sv @@
// ---------------------------------------------------------------------------
// LED bar serial display driver: byte sequencer
// Decodes one operation and steps through its command frames, one byte per
// push, reading and writing the segment cache as it goes.
// ---------------------------------------------------------------------------
`include "led_bar_serial_display_driver_defines.svh"

module lbsd_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2:0]            opcode,
    input  logic                  bar_select,
    input  logic [7:0]            led_count,
    input  logic                  display_on,
    input  logic [7:0]            bright_level,
    input  logic [7:0]            raw_byte,
    input  logic                  push_ok,
    output logic                  push,
    output lbsd_pkg::out_byte_t   out_byte,
    output lbsd_pkg::cache_req_t  cache_req,
    input  logic [7:0]            cache_data
);

    lbsd_pkg::seq_state_t          state_reg, state_next;
    logic                          flush_reg, flush_next;
    logic [lbsd_pkg::GRP_W-1:0]    idx_reg, idx_next;
    logic                          sel_reg, sel_next;
    logic [lbsd_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [7:0]                    single_reg, single_next;

    logic                          accept;
    logic                          pair;
    logic                          final_grp;
    logic [3:0]                    bar_addr;
    logic [3:0]                    flush_addr;
    logic [3:0]                    rd_addr4;
    logic [7:0]                    bright;

    assign s_tready = (state_reg == lbsd_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign push     = (state_reg != lbsd_pkg::ST_IDLE) && push_ok;

    assign bar_addr   = {1'b0, sel_reg, idx_reg[1:0]};
    assign flush_addr = {idx_reg, 1'b0};
    // An odd cache size leaves the final group with a single data byte.
    assign pair       = ({1'b0, flush_addr} + 5'd1) < 5'(lbsd_pkg::CACHE_WORDS);
    assign final_grp  = flush_reg ? (idx_reg == lbsd_pkg::GRP_W'(lbsd_pkg::FLUSH_GRPS - 1))
                                  : (idx_reg == lbsd_pkg::GRP_W'(lbsd_pkg::BAR_GRPS - 1));
    assign bright     = (bright_level > lbsd_pkg::MAX_BRIGHT) ? lbsd_pkg::MAX_BRIGHT
                                                              : bright_level;

    // Next state and captured item fields.
    always_comb
    begin
        state_next  = state_reg;
        flush_next  = flush_reg;
        idx_next    = idx_reg;
        sel_next    = sel_reg;
        count_next  = count_reg;
        single_next = single_reg;
        if (accept)
        begin
            case (opcode)
                lbsd_pkg::OP_BAR:
                begin
                    state_next = lbsd_pkg::ST_FIXED;
                    flush_next = 1'b0;
                    idx_next   = '0;
                    sel_next   = bar_select;
                    count_next = (led_count > 8'(lbsd_pkg::BAR_SEGMENTS))
                                 ? lbsd_pkg::CNT_W'(lbsd_pkg::BAR_SEGMENTS)
                                 : lbsd_pkg::CNT_W'(led_count);
                end
                lbsd_pkg::OP_DISPLAY:
                begin
                    state_next  = lbsd_pkg::ST_SINGLE;
                    single_next = display_on ? (lbsd_pkg::CMD_DISP_ON | bright)
                                             : lbsd_pkg::CMD_DISP_OFF;
                end
                lbsd_pkg::OP_RAW:
                begin
                    state_next  = lbsd_pkg::ST_SINGLE;
                    single_next = raw_byte;
                end
                lbsd_pkg::OP_FLUSH, lbsd_pkg::OP_CLEAR:
                begin
                    state_next = lbsd_pkg::ST_FIXED;
                    flush_next = 1'b1;
                    idx_next   = '0;
                end
                default:
                begin
                    state_next = lbsd_pkg::ST_IDLE;
                end
            endcase
        end
        else if (push)
        begin
            case (state_reg)
                lbsd_pkg::ST_SINGLE: state_next = lbsd_pkg::ST_IDLE;
                lbsd_pkg::ST_FIXED:  state_next = lbsd_pkg::ST_ADDR;
                lbsd_pkg::ST_ADDR:   state_next = lbsd_pkg::ST_DATA0;
                lbsd_pkg::ST_DATA0:
                begin
                    if (flush_reg && pair)
                    begin
                        state_next = lbsd_pkg::ST_DATA1;
                    end
                    else if (final_grp)
                    begin
                        state_next = lbsd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = lbsd_pkg::ST_FIXED;
                        idx_next   = idx_reg + 1'b1;
                    end
                end
                lbsd_pkg::ST_DATA1:
                begin
                    if (final_grp)
                    begin
                        state_next = lbsd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = lbsd_pkg::ST_FIXED;
                        idx_next   = idx_reg + 1'b1;
                    end
                end
                default: state_next = lbsd_pkg::ST_IDLE;
            endcase
        end
    end

    // Byte for the current step and cache accesses.
    always_comb
    begin
        out_byte = '0;
        case (state_reg)
            lbsd_pkg::ST_SINGLE:
            begin
                out_byte.data_byte      = single_reg;
                out_byte.frame_start    = 1'b1;
                out_byte.strobe_release = 1'b1;
                out_byte.last_byte      = 1'b1;
            end
            lbsd_pkg::ST_FIXED:
            begin
                out_byte.data_byte      = lbsd_pkg::CMD_FIXED;
                out_byte.frame_start    = 1'b1;
                out_byte.strobe_release = 1'b1;
            end
            lbsd_pkg::ST_ADDR:
            begin
                out_byte.data_byte   = lbsd_pkg::CMD_ADDR
                                       | {4'h0, (flush_reg ? flush_addr : bar_addr)};
                out_byte.frame_start = 1'b1;
            end
            lbsd_pkg::ST_DATA0:
            begin
                if (flush_reg)
                begin
                    out_byte.data_byte      = cache_data;
                    out_byte.strobe_release = !pair;
                    out_byte.last_byte      = !pair && final_grp;
                end
                else
                begin
                    out_byte.data_byte      = lbsd_pkg::therm_byte(count_reg, idx_reg[1:0]);
                    out_byte.strobe_release = 1'b1;
                    out_byte.last_byte      = final_grp;
                end
            end
            lbsd_pkg::ST_DATA1:
            begin
                out_byte.data_byte      = cache_data;
                out_byte.strobe_release = 1'b1;
                out_byte.last_byte      = final_grp;
            end
            default:
            begin
                out_byte = '0;
            end
        endcase
    end

    // The read address follows the step that comes next, so the registered
    // read data always belongs to the step in progress, even under stalls.
    assign rd_addr4 = {idx_next, (state_next == lbsd_pkg::ST_DATA1)};

    always_comb
    begin
        cache_req.wr_en   = push && (state_reg == lbsd_pkg::ST_DATA0) && !flush_reg
                            && ({1'b0, bar_addr} < 5'(lbsd_pkg::CACHE_WORDS));
        cache_req.wr_addr = lbsd_pkg::CACHE_AW'(bar_addr);
        cache_req.wr_data = lbsd_pkg::therm_byte(count_reg, idx_reg[1:0]);
        cache_req.clear   = accept && (opcode == lbsd_pkg::OP_CLEAR);
        cache_req.rd_addr = lbsd_pkg::CACHE_AW'(rd_addr4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lbsd_pkg::ST_IDLE;
            flush_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg    <= sel_next;
        count_reg  <= count_next;
        single_reg <= single_next;
    end

    `LBSD_ASSERT_NEXT(a_last_ends_item, clk, rst_n, push && out_byte.last_byte,
        state_reg == lbsd_pkg::ST_IDLE, "sequencer busy after final byte")
    `LBSD_ASSERT_NOW(a_write_only_bar, clk, rst_n, cache_req.wr_en,
        state_reg == lbsd_pkg::ST_DATA0 && !flush_reg, "cache write outside bar update")
    `LBSD_ASSERT_NEXT(a_flush_starts, clk, rst_n,
        accept && (opcode == lbsd_pkg::OP_FLUSH || opcode == lbsd_pkg::OP_CLEAR),
        state_reg == lbsd_pkg::ST_FIXED && flush_reg && idx_reg == '0,
        "flush did not start at the first group")

endmodule

@@ rtl/led_bar_serial_display_driver.sv @@
// ---------------------------------------------------------------------------
// LED bar serial display driver: top level
// Builds the strobe-framed command byte stream for a serial LED driver chip.
// ---------------------------------------------------------------------------
// Usage: an operation item enters on the s_ group; each command byte leaves
// as one item on the m_ group with its strobe marks in m_tuser and m_tlast
// set on the final byte of the operation.
// Bar update gives 12 bytes, display control and raw command 1 byte, flush
// and clear-and-flush 4 bytes per cached byte pair (32 for 16 bytes).
// Opcodes 5 to 7 are taken and give nothing.
// The sequencer handles one operation at a time: s_tready is high only when
// it is idle. A taken item is captured in the sequencer state register,
// and its bytes then pass through the output register, one byte per cycle
// while m_tready stays high. Flush data comes from the segment cache, read
// one step ahead through its registered port.
// A stalled m_tready holds the output item and pauses the sequencer.
// Reset clears the cache valid bits at once, so every segment byte reads as
// zero, and returns the sequencer to idle; no clearing pass is needed.
// ---------------------------------------------------------------------------
module led_bar_serial_display_driver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[2:0], bar_select[3], led_count[11:4], display_on[12],
    // bright_level[20:13], raw_byte[28:21], zero pad[31:29]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // data_byte[7:0]
    output logic [7:0]  m_tdata,
    // frame_start[0], strobe_release[1]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    lbsd_pkg::out_byte_t  seq_byte;
    lbsd_pkg::out_byte_t  out_reg;
    lbsd_pkg::cache_req_t cache_req;
    logic [7:0]           cache_data;
    logic                 push;
    logic                 push_ok;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    assign push_ok = !out_valid_reg || m_tready;

    lbsd_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .opcode       (s_tdata[2:0]),
        .bar_select   (s_tdata[3]),
        .led_count    (s_tdata[11:4]),
        .display_on   (s_tdata[12]),
        .bright_level (s_tdata[20:13]),
        .raw_byte     (s_tdata[28:21]),
        .push_ok      (push_ok),
        .push         (push),
        .out_byte     (seq_byte),
        .cache_req    (cache_req),
        .cache_data   (cache_data)
    );

    lbsd_cache u_cache (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (cache_req),
        .rd_data (cache_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_reg <= seq_byte;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data_byte;
    assign m_tuser  = {out_reg.strobe_release, out_reg.frame_start};
    assign m_tlast  = out_reg.last_byte;

endmodule
